// ===== hdl/assert_macros.svh =====
// Assertion macros for the port-level checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (reset is active low).
`define CMT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is also checked during reset.
`define CMT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cmt_pkg.sv =====
// Shared types and constants for the 8-bit compare-match timer.
// No dependencies.
package cmt_pkg;

    // Item kinds
    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_READ     = 3'd1,
        MODE_WRITE    = 3'd2,
        MODE_EXT_CLK  = 3'd3,
        MODE_EXT_RST  = 3'd4,
        MODE_FLAG_CLR = 3'd5
    } t_mode;

    // Register offsets
    localparam logic [2:0] OFF_CTRL   = 3'd0;
    localparam logic [2:0] OFF_STATUS = 3'd1;
    localparam logic [2:0] OFF_CMPA   = 3'd2;
    localparam logic [2:0] OFF_CMPB   = 3'd3;
    localparam logic [2:0] OFF_COUNT  = 3'd4;

    // Clock select codes (control bits 2..0)
    localparam logic [2:0] CKS_DIV8    = 3'd1;
    localparam logic [2:0] CKS_DIV64   = 3'd2;
    localparam logic [2:0] CKS_DIV1024 = 3'd3;
    localparam logic [2:0] CKS_RISE    = 3'd5;
    localparam logic [2:0] CKS_FALL    = 3'd6;
    localparam logic [2:0] CKS_BOTH    = 3'd7;

    // Counter clear select codes (control bits 4..3)
    localparam logic [1:0] CCLR_MATCH_A = 2'd1;
    localparam logic [1:0] CCLR_MATCH_B = 2'd2;
    localparam logic [1:0] CCLR_EXT     = 2'd3;

    // Output actions on match
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_SET    = 2'd2;
    localparam logic [1:0] ACT_TOGGLE = 2'd3;

    localparam logic [7:0] NO_REG_VALUE     = 8'hFF;
    localparam logic [7:0] CMP_RESET        = 8'hFF;
    localparam logic [7:0] COUNT_MAX        = 8'hFF;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] reg_offset;
        logic [7:0] write_data;
        logic       edge_rising;
        logic       clear_which;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_out;
        logic       irq_compare_a;
        logic       irq_compare_b;
        logic       irq_overflow;
    } t_result;

endpackage

// ===== hdl/cmt_engine.sv =====
// Timer register file and per-word update logic.
// Depends on cmt_pkg.
module cmt_engine
    import cmt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    logic [7:0] r_ctrl,  n_ctrl;
    logic [2:0] r_flags, n_flags;   // {CMFB, CMFA, OVF}
    logic [3:0] r_os,    n_os;      // output select, {B, A}
    logic [7:0] r_cmpa,  n_cmpa;
    logic [7:0] r_cmpb,  n_cmpb;
    logic [7:0] r_count, n_count;
    logic [2:0] r_seen,  n_seen;
    logic       r_out,   n_out;
    logic [9:0] r_presc, n_presc;

    // counter step outcome, from current state
    logic       ma, mb, clr;
    logic [1:0] act;
    logic [2:0] step_flags;
    logic       step_out;
    logic [7:0] step_count;
    logic [2:0] cks;
    logic [1:0] csel;
    logic [9:0] presc_inc;
    logic       tick_step;
    logic       ext_step;
    logic [2:0] cleared;
    logic [7:0] rd;

    assign cks  = r_ctrl[2:0];
    assign csel = r_ctrl[4:3];

    always_comb begin
        ma  = (r_count == r_cmpa);
        mb  = (r_count == r_cmpb);
        clr = ((csel == CCLR_MATCH_A) && ma) || ((csel == CCLR_MATCH_B) && mb);
        step_flags = r_flags | {mb, ma, (r_count == COUNT_MAX) && !clr};
        // highest action code wins: toggle > set > clear > none
        act = 2'd0;
        if (ma && (r_os[1:0] > act)) act = r_os[1:0];
        if (mb && (r_os[3:2] > act)) act = r_os[3:2];
        case (act)
            ACT_CLEAR:  step_out = 1'b0;
            ACT_SET:    step_out = 1'b1;
            ACT_TOGGLE: step_out = ~r_out;
            default:    step_out = r_out;
        endcase
        step_count = clr ? 8'd0 : r_count + 8'd1;
    end

    assign presc_inc = r_presc + 10'd1;

    always_comb begin
        case (cks)
            CKS_DIV8:    tick_step = (presc_inc[2:0] == 3'd0);
            CKS_DIV64:   tick_step = (presc_inc[5:0] == 6'd0);
            CKS_DIV1024: tick_step = (presc_inc == 10'd0);
            default:     tick_step = 1'b0;
        endcase
        ext_step = ((cks == CKS_RISE) && i_item.edge_rising)
                || ((cks == CKS_FALL) && !i_item.edge_rising)
                || (cks == CKS_BOTH);
    end

    always_comb begin
        n_ctrl  = r_ctrl;
        n_flags = r_flags;
        n_os    = r_os;
        n_cmpa  = r_cmpa;
        n_cmpb  = r_cmpb;
        n_count = r_count;
        n_seen  = r_seen;
        n_out   = r_out;
        n_presc = r_presc;
        rd      = 8'd0;
        cleared = ~i_item.write_data[7:5] & r_seen;
        case (t_mode'(i_item.mode))
            MODE_TICK: begin
                n_presc = presc_inc;
                if (tick_step) begin
                    n_flags = step_flags;
                    n_out   = step_out;
                    n_count = step_count;
                end
            end
            MODE_READ: begin
                case (i_item.reg_offset)
                    OFF_CTRL:   rd = r_ctrl;
                    OFF_STATUS: begin
                        rd     = {r_flags, 1'b1, r_os};
                        n_seen = r_seen | r_flags;
                    end
                    OFF_CMPA:   rd = r_cmpa;
                    OFF_CMPB:   rd = r_cmpb;
                    OFF_COUNT:  rd = r_count;
                    default:    rd = NO_REG_VALUE;
                endcase
            end
            MODE_WRITE: begin
                case (i_item.reg_offset)
                    OFF_CTRL:   n_ctrl = i_item.write_data;
                    OFF_STATUS: begin
                        n_flags = r_flags & ~cleared;
                        n_os    = i_item.write_data[3:0];
                        n_seen  = r_seen & ~cleared;
                    end
                    OFF_CMPA:   n_cmpa  = i_item.write_data;
                    OFF_CMPB:   n_cmpb  = i_item.write_data;
                    OFF_COUNT:  n_count = i_item.write_data;
                    default:    ;
                endcase
            end
            MODE_EXT_CLK: begin
                if (ext_step) begin
                    n_flags = step_flags;
                    n_out   = step_out;
                    n_count = step_count;
                end
            end
            MODE_EXT_RST: begin
                if (csel == CCLR_EXT) n_count = 8'd0;
            end
            MODE_FLAG_CLR: begin
                if (i_item.clear_which) n_flags[2] = 1'b0;
                else                    n_flags[1] = 1'b0;
            end
            default: ;
        endcase
    end

    assign o_result.read_data     = rd;
    assign o_result.timer_out     = n_out;
    assign o_result.irq_compare_a = n_flags[1] & n_ctrl[6];
    assign o_result.irq_compare_b = n_flags[2] & n_ctrl[7];
    assign o_result.irq_overflow  = n_flags[0] & n_ctrl[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl  <= 8'd0;
            r_flags <= 3'd0;
            r_os    <= 4'd0;
            r_cmpa  <= CMP_RESET;
            r_cmpb  <= CMP_RESET;
            r_count <= 8'd0;
            r_seen  <= 3'd0;
            r_out   <= 1'b0;
            r_presc <= 10'd0;
        end else if (i_fire) begin
            r_ctrl  <= n_ctrl;
            r_flags <= n_flags;
            r_os    <= n_os;
            r_cmpa  <= n_cmpa;
            r_cmpb  <= n_cmpb;
            r_count <= n_count;
            r_seen  <= n_seen;
            r_out   <= n_out;
            r_presc <= n_presc;
        end
    end

endmodule

// ===== hdl/eight_bit_compare_match_timer_core.sv =====
// Top level of the 8-bit compare-match timer: input and result registers
// around the timer engine. Depends on cmt_pkg and cmt_engine.
//
// Each input word is one event seen by the timer: a phi tick, a register
// read or write, an external clock or reset edge, or a flag clear. Every
// word returns exactly one result word carrying read data (zero unless the
// word was a read), the output pin level and the three interrupt requests
// after the event. The block takes one word per clock while the output side
// is not stalled and passes each word through the input register, then one
// read-modify-write of the timer registers that loads the result register;
// the register file updates once per word as it moves on. A stall on the
// output side holds the result register; one more word may then sit in the
// input register before o_in_stall rises. No clearing pass after reset: all
// state resets directly.
module eight_bit_compare_match_timer_core
    import cmt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_mode,
    input  logic [2:0] i_reg_offset,
    input  logic [7:0] i_write_data,
    input  logic       i_edge_rising,
    input  logic       i_clear_which,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_timer_out,
    output logic       o_irq_compare_a,
    output logic       o_irq_compare_b,
    output logic       o_irq_overflow
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result eng_result;

    logic accept_in;
    logic out_free;
    logic move;

    // result register can load when empty or being emptied this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign accept_in  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept_in) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_item.mode        <= i_mode;
            r_item.reg_offset  <= i_reg_offset;
            r_item.write_data  <= i_write_data;
            r_item.edge_rising <= i_edge_rising;
            r_item.clear_which <= i_clear_which;
        end
    end

    // state updates exactly once per word, when it moves to the result reg
    cmt_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (move),
        .i_item   (r_item),
        .o_result (eng_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_result <= eng_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_data     = r_result.read_data;
    assign o_timer_out     = r_result.timer_out;
    assign o_irq_compare_a = r_result.irq_compare_a;
    assign o_irq_compare_b = r_result.irq_compare_b;
    assign o_irq_overflow  = r_result.irq_overflow;

endmodule

// ===== hdl/cmt_checker.sv =====
// Port-level checks for the compare-match timer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module cmt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [2:0] i_mode,
    input logic [2:0] i_reg_offset,
    input logic [7:0] i_write_data,
    input logic       i_edge_rising,
    input logic       i_clear_which,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_read_data,
    input logic       o_timer_out,
    input logic       o_irq_compare_a,
    input logic       o_irq_compare_b,
    input logic       o_irq_overflow
);

    // a stalled result word holds
    `CMT_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable({o_read_data, o_timer_out, o_irq_compare_a, o_irq_compare_b, o_irq_overflow}), "result changed under stall")

    // input stalls only when the result word is blocked
    `CMT_ASSERT(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall, "input stalled without output backpressure")

    // a new result needs an earlier accepted word, passed through the input register
    `CMT_ASSERT(a_no_invent, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2), "result appeared without an input word")

    // nothing pending on the first clock out of reset
    `CMT_ASSERT(a_reset_idle, i_clk, i_rst_n, !$past(i_rst_n) |-> !o_out_valid && !o_in_stall, "pipeline not empty after reset")

endmodule

bind eight_bit_compare_match_timer_core cmt_checker u_cmt_checker (.*);

// ===== sim/cmt_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the 8-bit compare-match timer: watches both channels,
// predicts every result word and compares it field by field. Needs cmt_pkg.
module cmt_result_checker
    import cmt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel as seen at the block
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [2:0]  i_reg_offset,
    input  logic [7:0]  i_write_data,
    input  logic        i_edge_rising,
    input  logic        i_clear_which,
    // result channel
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_read_data,
    input  logic        i_timer_out,
    input  logic        i_irq_compare_a,
    input  logic        i_irq_compare_b,
    input  logic        i_irq_overflow,
    output logic [31:0] o_mismatch_count,
    output logic [31:0] o_results_pending
);

    localparam logic [7:0] FLAG_BITS      = 8'hE0;
    localparam logic [7:0] OUT_ACT_BITS   = 8'h0F;
    localparam logic [7:0] STATUS_ONE_BIT = 8'h10;
    // flag and interrupt enable share a bit position in status and control
    localparam int BIT_CMFB = 7;
    localparam int BIT_CMFA = 6;
    localparam int BIT_OVF  = 5;
    localparam int REPORT_LIMIT = 10;

    logic [7:0] ctrl_q;
    logic [7:0] status_q;
    logic [7:0] cmpa_q;
    logic [7:0] cmpb_q;
    logic [7:0] count_q;
    logic [2:0] seen_q;      // flags read as 1 since last cleared
    logic       pin_q;
    logic [9:0] presc_q;

    t_result predicted_results[$];
    int      mismatches = 0;
    int      results_seen = 0;

    task automatic step_counter();
        logic       ma;
        logic       mb;
        logic       clr;
        logic [1:0] act;
        ma  = (count_q == cmpa_q);
        mb  = (count_q == cmpb_q);
        clr = (ctrl_q[4:3] == CCLR_MATCH_A && ma) || (ctrl_q[4:3] == CCLR_MATCH_B && mb);
        if (ma) status_q[BIT_CMFA] = 1'b1;
        if (mb) status_q[BIT_CMFB] = 1'b1;
        if (count_q == COUNT_MAX && !clr) status_q[BIT_OVF] = 1'b1;
        // strongest action wins: toggle > set > clear > none
        act = 2'd0;
        if (ma && status_q[1:0] > act) act = status_q[1:0];
        if (mb && status_q[3:2] > act) act = status_q[3:2];
        case (act)
            ACT_CLEAR:  pin_q = 1'b0;
            ACT_SET:    pin_q = 1'b1;
            ACT_TOGGLE: pin_q = ~pin_q;
            default: ;
        endcase
        count_q = clr ? 8'h00 : count_q + 8'd1;
    endtask

    task automatic apply_timer_event(input t_item w, output t_result r);
        logic [9:0] div_mask;
        logic [7:0] seen_bits;
        logic [7:0] cleared;
        r = '0;
        case (w.mode)
            MODE_TICK: begin
                case (ctrl_q[2:0])
                    CKS_DIV8:    div_mask = 10'h007;
                    CKS_DIV64:   div_mask = 10'h03F;
                    CKS_DIV1024: div_mask = 10'h3FF;
                    default:     div_mask = 10'h000;
                endcase
                presc_q = presc_q + 10'd1;
                if (div_mask != 10'h000 && (presc_q & div_mask) == 10'h000) step_counter();
            end
            MODE_READ: begin
                case (w.reg_offset)
                    OFF_CTRL:   r.read_data = ctrl_q;
                    OFF_STATUS: begin
                        seen_q      = seen_q | status_q[7:5];
                        r.read_data = status_q | STATUS_ONE_BIT;
                    end
                    OFF_CMPA:   r.read_data = cmpa_q;
                    OFF_CMPB:   r.read_data = cmpb_q;
                    OFF_COUNT:  r.read_data = count_q;
                    default:    r.read_data = NO_REG_VALUE;
                endcase
            end
            MODE_WRITE: begin
                case (w.reg_offset)
                    OFF_CTRL:   ctrl_q = w.write_data;
                    OFF_STATUS: begin
                        // a flag clears only if written 0 after being read as 1
                        seen_bits = {seen_q, 5'b0};
                        cleared   = ~w.write_data & seen_bits & FLAG_BITS;
                        status_q  = (status_q & FLAG_BITS & ~cleared)
                                  | (w.write_data & OUT_ACT_BITS);
                        seen_q    = seen_q & ~cleared[7:5];
                    end
                    OFF_CMPA:   cmpa_q = w.write_data;
                    OFF_CMPB:   cmpb_q = w.write_data;
                    OFF_COUNT:  count_q = w.write_data;
                    default: ;
                endcase
            end
            MODE_EXT_CLK: begin
                if ((ctrl_q[2:0] == CKS_RISE && w.edge_rising)
                        || (ctrl_q[2:0] == CKS_FALL && !w.edge_rising)
                        || ctrl_q[2:0] == CKS_BOTH)
                    step_counter();
            end
            MODE_EXT_RST: begin
                if (ctrl_q[4:3] == CCLR_EXT) count_q = 8'h00;
            end
            MODE_FLAG_CLR: begin
                if (w.clear_which) status_q[BIT_CMFB] = 1'b0;
                else status_q[BIT_CMFA] = 1'b0;
            end
            default: ;
        endcase
        r.timer_out     = pin_q;
        r.irq_compare_a = status_q[BIT_CMFA] & ctrl_q[BIT_CMFA];
        r.irq_compare_b = status_q[BIT_CMFB] & ctrl_q[BIT_CMFB];
        r.irq_overflow  = status_q[BIT_OVF] & ctrl_q[BIT_OVF];
    endtask

    always @(posedge i_clk) begin : watch
        t_item   word;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            ctrl_q   = 8'h00;
            status_q = 8'h00;
            cmpa_q   = CMP_RESET;
            cmpb_q   = CMP_RESET;
            count_q  = 8'h00;
            seen_q   = 3'b000;
            pin_q    = 1'b0;
            presc_q  = 10'h000;
            predicted_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_read_data, i_timer_out, i_irq_compare_a, i_irq_compare_b,
                       i_irq_overflow};
                results_seen++;
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result word %0d arrived with none expected: %h",
                                 results_seen, got);
                end else begin
                    want = predicted_results.pop_front();
                    if (got.read_data !== want.read_data || got.timer_out !== want.timer_out
                            || got.irq_compare_a !== want.irq_compare_a
                            || got.irq_compare_b !== want.irq_compare_b
                            || got.irq_overflow !== want.irq_overflow) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"result word %0d: read_data exp %02h got %02h, ",
                                      "pin exp %b got %b, irq a/b/ovf exp %b%b%b got %b%b%b"},
                                     results_seen, want.read_data, got.read_data,
                                     want.timer_out, got.timer_out,
                                     want.irq_compare_a, want.irq_compare_b,
                                     want.irq_overflow, got.irq_compare_a,
                                     got.irq_compare_b, got.irq_overflow);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                word = {i_mode, i_reg_offset, i_write_data, i_edge_rising, i_clear_which};
                apply_timer_event(word, want);
                predicted_results.push_back(want);
            end
        end
        o_mismatch_count  = mismatches;
        o_results_pending = predicted_results.size();
    end

endmodule

// ===== sim/tb_eight_bit_compare_match_timer_core.sv =====
`timescale 1ns / 1ps
// Testbench top for eight_bit_compare_match_timer_core: drives event words,
// shapes stalls on the result side and gives the verdict.
// Depends on cmt_pkg, cmt_result_checker and the block itself.
module tb_eight_bit_compare_match_timer_core;
    import cmt_pkg::*;

    localparam int CLK_HALF_NS      = 4;     // 8 ns period
    localparam int RESET_CYCLES     = 12;
    localparam int TARGET_WORDS     = 1350;  // directed plus random words
    localparam int IDLE_LIMIT       = 2000;  // cycles with no handshake at all
    localparam int LONG_HOLD_CYCLES = 300;   // receiver hold-off, fills the block
    localparam int TAIL_CYCLES      = 8;     // generous tail after the last result

    // modes and offsets the package leaves unnamed; the block must ignore them
    localparam logic [2:0] MODE_SPARE_6     = 3'd6;
    localparam logic [2:0] MODE_SPARE_7     = 3'd7;
    localparam logic [2:0] OFF_UNUSED_LAST  = 3'd7;
    // clock select codes that stop the counter
    localparam logic [2:0] CKS_STOP         = 3'd0;
    localparam logic [2:0] CKS_STOP_ALT     = 3'd4;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [2:0] mode        = MODE_TICK;
    logic [2:0] reg_offset  = OFF_CTRL;
    logic [7:0] write_data  = 8'h00;
    logic       edge_rising = 1'b0;
    logic       clear_which = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [7:0] read_data;
    logic       timer_out;
    logic       irq_compare_a;
    logic       irq_compare_b;
    logic       irq_overflow;

    logic [31:0] mismatch_count;
    logic [31:0] results_pending;

    int burst_left    = 0;     // words left in the current sender burst
    int words_sent    = 0;
    bit long_hold_req = 1'b0;  // asks the receiver for one long hold-off

    always #CLK_HALF_NS clk = ~clk;

    eight_bit_compare_match_timer_core u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_mode          (mode),
        .i_reg_offset    (reg_offset),
        .i_write_data    (write_data),
        .i_edge_rising   (edge_rising),
        .i_clear_which   (clear_which),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_read_data     (read_data),
        .o_timer_out     (timer_out),
        .o_irq_compare_a (irq_compare_a),
        .o_irq_compare_b (irq_compare_b),
        .o_irq_overflow  (irq_overflow)
    );

    cmt_result_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_mode            (mode),
        .i_reg_offset      (reg_offset),
        .i_write_data      (write_data),
        .i_edge_rising     (edge_rising),
        .i_clear_which     (clear_which),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_read_data       (read_data),
        .i_timer_out       (timer_out),
        .i_irq_compare_a   (irq_compare_a),
        .i_irq_compare_b   (irq_compare_b),
        .i_irq_overflow    (irq_overflow),
        .o_mismatch_count  (mismatch_count),
        .o_results_pending (results_pending)
    );

    function automatic t_item make_word(input logic [2:0] kind, input logic [2:0] off,
                                        input logic [7:0] data, input logic rise,
                                        input logic which);
        t_item w;
        w.mode        = kind;
        w.reg_offset  = off;
        w.write_data  = data;
        w.edge_rising = rise;
        w.clear_which = which;
        return w;
    endfunction

    // Fields a word does not use still carry random bits.
    function automatic t_item random_word(input logic [2:0] kind, input logic [2:0] off);
        t_item w;
        w            = 16'($urandom_range(0, 16'hFFFF));
        w.mode       = kind;
        w.reg_offset = off;
        return w;
    endfunction

    // One random event inside a timer scenario. Internal clocking gets mostly
    // phi ticks, external clocking mostly pin edges; the rest is bus traffic,
    // flag handling and words the block should ignore.
    function automatic t_item random_event(input bit phi_clocked);
        int    r;
        t_item w;
        r = $urandom_range(0, 99);
        w = random_word(MODE_TICK, 3'($urandom_range(0, 7)));
        if (r < (phi_clocked ? 55 : 20)) begin
            w.mode = MODE_TICK;
        end else if (r < 60) begin
            w.mode = MODE_EXT_CLK;
        end else if (r < 68) begin
            // status reads arm the flag clear
            w.mode       = MODE_READ;
            w.reg_offset = OFF_STATUS;
        end else if (r < 73) begin
            w.mode = MODE_READ;
        end else if (r < 79) begin
            w.mode       = MODE_WRITE;
            w.reg_offset = OFF_STATUS;
        end else if (r < 83) begin
            w.mode = MODE_FLAG_CLR;
        end else if (r < 87) begin
            w.mode = MODE_EXT_RST;
        end else if (r < 91) begin
            w.mode = MODE_WRITE;
        end else if (r < 95) begin
            w.mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
        end else begin
            w.mode       = MODE_READ;
            w.reg_offset = OFF_COUNT;
        end
        return w;
    endfunction

    // Offer one word and hold it until accepted. Bursts of random length with
    // random gaps in front; stall is looked at on the falling edge, where it
    // is settled for the coming rising edge.
    task automatic send_word(input t_item w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        {mode, reg_offset, write_data, edge_rising, clear_which} <= w;
        do @(negedge clk); while (in_stall);
        @(posedge clk);
        words_sent++;
    endtask

    task automatic send_write(input logic [2:0] off, input logic [7:0] data);
        t_item w;
        w            = random_word(MODE_WRITE, off);
        w.write_data = data;
        send_word(w);
    endtask

    // Sender goes quiet until every predicted result has come back.
    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (results_pending != 0);
        @(posedge clk);
    endtask

    // Well-formed setup (control, counter near compare values, output actions)
    // followed by a run of events with random content.
    task automatic run_timer_scenario();
        logic [2:0] cks;
        logic [7:0] ctl;
        logic [7:0] base;
        bit         phi_clocked;
        int         events;
        case ($urandom_range(0, 9))
            0, 1:    cks = CKS_DIV8;
            2:       cks = CKS_DIV64;
            3:       cks = CKS_DIV1024;
            4, 5:    cks = CKS_BOTH;
            6:       cks = CKS_RISE;
            7:       cks = CKS_FALL;
            default: cks = $urandom_range(0, 1) ? CKS_STOP : CKS_STOP_ALT;
        endcase
        phi_clocked = (cks == CKS_DIV8 || cks == CKS_DIV64 || cks == CKS_DIV1024);
        ctl      = 8'($urandom_range(0, 255));
        ctl[2:0] = cks;
        // half the time start just below the wrap so overflow shows up
        base = $urandom_range(0, 1) ? COUNT_MAX - 8'($urandom_range(0, 7))
                                    : 8'($urandom_range(0, 255));
        send_write(OFF_CTRL, ctl);
        if ($urandom_range(0, 3) != 0) send_write(OFF_COUNT, base);
        if ($urandom_range(0, 3) != 0) send_write(OFF_CMPA, base + 8'($urandom_range(0, 4)));
        if ($urandom_range(0, 3) != 0) send_write(OFF_CMPB, base + 8'($urandom_range(0, 6)));
        if ($urandom_range(0, 3) != 0) send_write(OFF_STATUS, 8'($urandom_range(0, 255)));
        events = $urandom_range(8, 40);
        if (phi_clocked) events = events * 3;
        // now and then a long tick run so the prescaler wraps
        if ($urandom_range(0, 7) == 0) events = $urandom_range(100, 250);
        repeat (events) send_word(random_event(phi_clocked));
    endtask

    initial begin : stimulus
        int scenario;
        scenario = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // every offset read back at reset values, unused ones included
        for (int off = 0; off < 8; off++)
            send_word(make_word(MODE_READ, 3'(off), 8'h00, 1'b0, 1'b0));
        // counter one below the wrap, match A at zero, match B at the top,
        // toggle on both matches, all interrupts on, clear on external reset
        send_word(make_word(MODE_WRITE, OFF_CMPA, 8'h00, 1'b0, 1'b0));
        send_word(make_word(MODE_WRITE, OFF_CMPB, CMP_RESET, 1'b1, 1'b1));
        send_word(make_word(MODE_WRITE, OFF_COUNT, COUNT_MAX - 8'd1, 1'b0, 1'b0));
        send_word(make_word(MODE_WRITE, OFF_STATUS, {4'h0, ACT_TOGGLE, ACT_TOGGLE},
                            1'b0, 1'b0));
        send_word(make_word(MODE_WRITE, OFF_CTRL, {3'b111, CCLR_EXT, CKS_BOTH}, 1'b0, 1'b0));
        // both edge directions step; second step hits match B and overflow,
        // third hits match A
        send_word(make_word(MODE_EXT_CLK, OFF_CTRL, 8'h00, 1'b1, 1'b0));
        send_word(make_word(MODE_EXT_CLK, OFF_CTRL, 8'h00, 1'b0, 1'b0));
        send_word(make_word(MODE_EXT_CLK, OFF_CTRL, 8'h00, 1'b1, 1'b0));
        send_word(make_word(MODE_EXT_RST, OFF_CTRL, 8'h00, 1'b0, 1'b0));
        // read arms the flags, direct clear of CMFB, then a zero write clears
        // the rest; the final CMFA clear finds nothing left to clear
        send_word(make_word(MODE_READ, OFF_STATUS, 8'h00, 1'b0, 1'b0));
        send_word(make_word(MODE_FLAG_CLR, OFF_CTRL, 8'h00, 1'b0, 1'b1));
        send_word(make_word(MODE_WRITE, OFF_STATUS, 8'h00, 1'b0, 1'b0));
        send_word(make_word(MODE_FLAG_CLR, OFF_CTRL, 8'h00, 1'b0, 1'b0));
        // writes to an unused offset and the spare modes change nothing
        send_word(make_word(MODE_WRITE, OFF_UNUSED_LAST, 8'hFF, 1'b1, 1'b1));
        send_word(make_word(MODE_SPARE_6, OFF_UNUSED_LAST, 8'hFF, 1'b1, 1'b1));
        send_word(make_word(MODE_SPARE_7, OFF_STATUS, 8'hFF, 1'b1, 1'b1));
        drain_results();

        // --- random part ---
        // the receiver holds off for a long stretch while words keep coming
        @(negedge clk);
        long_hold_req = 1'b1;
        @(posedge clk);
        while (words_sent < TARGET_WORDS) begin
            run_timer_scenario();
            scenario++;
            if (scenario % 8 == 0) drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("eight_bit_compare_match_timer_core: match");
        end else begin
            $display("eight_bit_compare_match_timer_core: mismatch");
        end
        $finish;
    end

    // Receiver stall pattern: segments of random length, each with its own
    // style (no stall, light, heavy, mostly stalled), plus the one long hold.
    initial begin : result_stalls
        int seg_len;
        int style;
        bit long_hold_done;
        long_hold_done = 1'b0;
        forever begin
            seg_len = $urandom_range(8, 120);
            style   = $urandom_range(0, 3);
            repeat (seg_len) begin
                @(posedge clk);
                if (long_hold_req && !long_hold_done) begin
                    long_hold_done = 1'b1;
                    out_stall <= 1'b1;
                    repeat (LONG_HOLD_CYCLES) @(posedge clk);
                end
                case (style)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 7) == 0);
                    2:       out_stall <= $urandom_range(0, 1);
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run if no word moves on either channel for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(negedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("eight_bit_compare_match_timer_core: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/cmt_pkg.sv
hdl/cmt_engine.sv
hdl/eight_bit_compare_match_timer_core.sv
hdl/cmt_checker.sv
sim/cmt_result_checker.sv
sim/tb_eight_bit_compare_match_timer_core.sv
